FILE: rtl/core/bhcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhcf_pkg
// Shared types, constants and helpers for the byte histogram with case fold.
// ----------------------------------------------------------------------------
package bhcf_pkg;

	localparam int NUM_BINS    = 256;
	localparam int ADDR_WIDTH  = $clog2(NUM_BINS);
	localparam int COUNT_WIDTH = 32;

	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [7:0] UPPER_FIRST = 8'h41;
	localparam logic [7:0] UPPER_LAST  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef logic [ADDR_WIDTH-1:0]  addr_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	// operation held in the update stage
	typedef struct packed {
		logic       vld;
		logic [1:0] cmd;
		addr_t      addr;
	} op_t;

	// ascii upper case to lower case when folding is on
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
		logic [7:0] r;
		r = b;
		if (fold_en && b >= UPPER_FIRST && b <= UPPER_LAST) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bhcf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhcf_ram
// Bin count store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bhcf_ram (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire bhcf_pkg::addr_t  rd_addr,
	output      bhcf_pkg::count_t rd_data,
	input  wire logic             wr_en,
	input  wire bhcf_pkg::addr_t  wr_addr,
	input  wire bhcf_pkg::count_t wr_data
);
	import bhcf_pkg::*;

	count_t mem [NUM_BINS];
	count_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/core/bhcf_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhcf_update
// Read-modify-write stage: bin valid bits, write forwarding, saturating
// increment and the registered read result.
// ----------------------------------------------------------------------------
module bhcf_update (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bhcf_pkg::op_t    op_s1,
	input  wire bhcf_pkg::count_t rd_data,
	output      logic             wr_en,
	output      bhcf_pkg::addr_t  wr_addr,
	output      bhcf_pkg::count_t wr_data,
	output      logic             res_strobe,
	output      bhcf_pkg::addr_t  res_index,
	output      bhcf_pkg::count_t res_count
);
	import bhcf_pkg::*;

	logic [NUM_BINS-1:0] valid_q;
	logic                wr_en_q;
	addr_t               wr_addr_q;
	count_t              wr_data_q;
	logic                strobe_q;
	addr_t               index_q;
	count_t              count_q;

	logic   is_count;
	logic   is_read;
	logic   is_clear;
	logic   fwd_hit;
	count_t cur;
	count_t nxt;

	assign is_count = op_s1.vld && (op_s1.cmd == CMD_COUNT);
	assign is_read  = op_s1.vld && (op_s1.cmd == CMD_READ);
	assign is_clear = op_s1.vld && (op_s1.cmd == CMD_CLEAR);

	// memory read was issued while the previous word was still being written
	assign fwd_hit = wr_en_q && (wr_addr_q == op_s1.addr);

	always_comb begin
		if (fwd_hit) begin
			cur = wr_data_q;
		end else if (valid_q[op_s1.addr]) begin
			cur = rd_data;
		end else begin
			cur = '0;
		end
		nxt = (&cur) ? cur : cur + count_t'(1);
	end

	assign wr_en   = is_count;
	assign wr_addr = op_s1.addr;
	assign wr_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			wr_en_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (is_clear) begin
				valid_q <= '0;
			end else if (is_count) begin
				valid_q[op_s1.addr] <= 1'b1;
			end
			wr_en_q  <= is_count;
			strobe_q <= is_read;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= op_s1.addr;
		wr_data_q <= nxt;
		index_q   <= op_s1.addr;
		count_q   <= cur;
	end

	assign res_strobe = strobe_q;
	assign res_index  = index_q;
	assign res_count  = count_q;

endmodule
`default_nettype wire

FILE: rtl/core/byte_histogram_case_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_histogram_case_fold
// 256-bin byte histogram with optional ascii case folding.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge with start high and busy low;
// busy stays low, so a word can be issued every cycle.
//   count: adds one to the bin of byte_value (saturating), 'A'..'Z' go to
//          'a'..'z' when fold_case is set
//   read:  returns bin byte_value (never folded) on bin_index / bin_count,
//          marked by result_strobe once it has passed the op_s1 and result registers
//   clear: zeroes all bins together
// Count, clear and unused codes give no result. Throughput is one word per
// cycle: each word reads the bin memory once and a count writes it back;
// its registered read data is covered by forwarding from the previous write.
// Per-bin valid bits make clear and reset take effect at once, with no
// sweep of the memory. fold_case is written through cfg_we / cfg_data and
// resets to 0. A result is shown for one cycle only; the receiver cannot
// stall it.
// ----------------------------------------------------------------------------
module byte_histogram_case_fold (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  byte_value,
	input  wire logic        cfg_we,
	input  wire logic        cfg_data,
	output      logic        result_strobe,
	output      logic [7:0]  bin_index,
	output      logic [31:0] bin_count
);
	import bhcf_pkg::*;

	logic       fold_q;
	logic       accept;
	addr_t      addr_in;
	logic       op_vld_s1;
	logic [1:0] op_cmd_s1;
	addr_t      op_addr_s1;
	op_t        op_s1;
	count_t     rd_data;
	logic       wr_en;
	addr_t      wr_addr;
	count_t     wr_data;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// only counted bytes are folded
	assign addr_in = (cmd == CMD_COUNT) ? fold_byte(byte_value, fold_q) : byte_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q    <= 1'b0;
			op_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				fold_q <= cfg_data;
			end
			op_vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_cmd_s1  <= cmd;
		op_addr_s1 <= addr_in;
	end

	assign op_s1 = '{vld: op_vld_s1, cmd: op_cmd_s1, addr: op_addr_s1};

	bhcf_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (addr_in),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bhcf_update u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_s1      (op_s1),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.res_strobe (result_strobe),
		.res_index  (bin_index),
		.res_count  (bin_count)
	);

	// every accepted read gives exactly one result, through the op_s1 and result registers
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_READ) |=> ##1 result_strobe)
		else $error("read word produced no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(op_s1.vld && op_s1.cmd == CMD_READ))
		else $error("result without a read word");

	// a saturating counter never writes back zero
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_data != '0))
		else $error("bin counter wrapped");

endmodule
`default_nettype wire
